### design/mbp_pkg.sv
// Shared types, constants and fixed-point helpers of the perturbation pixel core.
// Used by every module of the design but mbp_ram; depends on nothing.
package mbp_pkg;

  localparam int unsigned OrbitDepthDef = 1024;
  localparam int unsigned MaxColumnsDef = 1024;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned FracBits      = 27;
  localparam int unsigned QueueDepth    = 2;

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CMax = coord_t'({1'b0, {(CoordW-1){1'b1}}});
  localparam coord_t CMin = coord_t'({1'b1, {(CoordW-1){1'b0}}});

  localparam logic [64:0] NormOrbit  = 65'(16) << (2 * FracBits);
  localparam logic [64:0] NormEscape = 65'(4) << (2 * FracBits);
  localparam logic [64:0] NormRebase = 65'(64) << (2 * FracBits);

  localparam logic [63:0] PalR = 64'd2295;
  localparam logic [63:0] PalG = 64'd3825;
  localparam logic [63:0] PalB = 64'd4335;

  typedef enum logic [2:0] {
    CFG_CENTER_RE = 3'd0,
    CFG_CENTER_IM = 3'd1,
    CFG_LEFT_EDGE = 3'd2,
    CFG_TOP_EDGE  = 3'd3,
    CFG_PITCH_X   = 3'd4,
    CFG_PITCH_Y   = 3'd5,
    CFG_MAX_ITER  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    CMD_BUILD  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_B_CHECK, ST_B_1, ST_B_2, ST_B_3, ST_B_4, ST_B_5, ST_B_6,
    ST_P_CHECK, ST_P_0, ST_P_1, ST_P_2, ST_P_3, ST_P_4, ST_P_5, ST_P_6,
    ST_P_7, ST_P_8, ST_P_9, ST_P_10, ST_P_11, ST_P_12, ST_P_13,
    ST_C_0, ST_C_1, ST_C_2, ST_C_3, ST_C_4, ST_C_5, ST_C_6, ST_C_7, ST_C_8,
    ST_DIV, ST_DONE
  } st_e;

  typedef struct packed {
    logic       command;
    logic [9:0] column;
    logic [9:0] row;
  } in_item_t;

  typedef struct packed {
    logic [12:0] iterations;
    logic [15:0] color;
    logic        escaped;
    logic        needs_rebase;
    logic [10:0] orbit_length;
  } out_item_t;

  typedef struct packed {
    coord_t      center_re;
    coord_t      center_im;
    coord_t      left_edge;
    coord_t      top_edge;
    logic [30:0] pitch_x;
    logic [30:0] pitch_y;
    logic [12:0] max_iter;
  } cfg_t;

  typedef struct packed {
    logic   command;
    coord_t cx;
    coord_t cy;
  } job_t;

  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic [CoordW:0] s;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    if (s[CoordW] != s[CoordW-1]) begin
      return s[CoordW] ? CMin : CMax;
    end
    return s[CoordW-1:0];
  endfunction

  function automatic coord_t sat_sub(coord_t a, coord_t b);
    logic [CoordW:0] s;
    s = {a[CoordW-1], a} - {b[CoordW-1], b};
    if (s[CoordW] != s[CoordW-1]) begin
      return s[CoordW] ? CMin : CMax;
    end
    return s[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] mag(coord_t a);
    logic [CoordW-1:0] u;
    u = a;
    return a[CoordW-1] ? (~u + 1'b1) : u;
  endfunction

  // Truncates a magnitude product toward zero and saturates it with its sign.
  function automatic coord_t fx_from_prod(logic [2*CoordW-1:0] p, logic neg);
    logic [2*CoordW-1:0] q;
    logic [2*CoordW-1:0] lim;
    logic [CoordW-1:0]   qs;
    q   = p >> FracBits;
    lim = neg ? ((2*CoordW)'(1) << (CoordW-1)) : (((2*CoordW)'(1) << (CoordW-1)) - 1'b1);
    if (q > lim) begin
      q = lim;
    end
    qs = q[CoordW-1:0];
    return neg ? coord_t'(~qs + 1'b1) : coord_t'(qs);
  endfunction

endpackage

### design/mbp_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing; used for the stored reference orbit.
module mbp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mbp_front.sv
// Front end: accepts commands and forms the pixel point from column and row.
// Depends on mbp_pkg; feeds the job queue.
module mbp_front #(
  parameter int unsigned MAX_COLUMNS = mbp_pkg::MaxColumnsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mbp_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mbp_pkg::in_item_t in_data_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output mbp_pkg::job_t    push_data_o
);

  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [40:0] px_q;
  logic [40:0] py_q;
  logic [9:0]  col_c;
  logic        accept;
  logic        push;

  function automatic mbp_pkg::coord_t clamp_point(mbp_pkg::coord_t e, logic [40:0] p);
    logic signed [41:0] s;
    s = {{10{e[31]}}, e} + {1'b0, p};
    if (s > 42'sd2147483647) begin
      return mbp_pkg::CMax;
    end
    if (s < -42'sd2147483648) begin
      return mbp_pkg::CMin;
    end
    return s[31:0];
  endfunction

  always_comb begin
    col_c = in_data_i.column;
    if (32'(in_data_i.column) >= 32'(MAX_COLUMNS)) begin
      col_c = 10'(MAX_COLUMNS - 1);
    end
  end

  assign push       = s1_valid_q && push_ready_i;
  assign in_stall_o = s1_valid_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (push) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= in_data_i.command;
      px_q     <= 41'(col_c) * 41'(cfg_i.pitch_x);
      py_q     <= 41'(in_data_i.row) * 41'(cfg_i.pitch_y);
    end
  end

  assign push_valid_o        = s1_valid_q;
  assign push_data_o.command = s1_cmd_q;
  assign push_data_o.cx      = clamp_point(cfg_i.left_edge, px_q);
  assign push_data_o.cy      = clamp_point(cfg_i.top_edge, py_q);

endmodule

### design/mbp_queue.sv
// Short job queue between the front end and the iteration engine.
// Depends on mbp_pkg.
module mbp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mbp_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output mbp_pkg::job_t pop_data_o
);

  localparam int unsigned PW = $clog2(mbp_pkg::QueueDepth);

  mbp_pkg::job_t entry_q [mbp_pkg::QueueDepth];
  logic [PW-1:0] wr_q;
  logic [PW-1:0] rd_q;
  logic [PW:0]   fill_q;
  logic          push;
  logic          pop;

  assign push_ready_o = fill_q != (PW+1)'(mbp_pkg::QueueDepth);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

### design/mbp_back.sv
// Iteration engine: orbit build, perturbation render and color gradient.
// Depends on mbp_pkg and mbp_ram; one shared 32x32 multiplier does all products but the palette scalings.
module mbp_back #(
  parameter int unsigned ORBIT_DEPTH = mbp_pkg::OrbitDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbp_pkg::cfg_t      cfg_i,
  input  logic               job_valid_i,
  input  mbp_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mbp_pkg::out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(ORBIT_DEPTH);
  localparam int unsigned CW = $clog2(ORBIT_DEPTH + 1);
  localparam int unsigned W  = mbp_pkg::CoordW;

  mbp_pkg::st_e st_q, st_d;

  mbp_pkg::coord_t zr_q, zi_q, dr_q, di_q, dcr_q, dci_q, cre_q, cim_q;
  mbp_pkg::coord_t t1_q, a_q, b_q;
  logic [CW-1:0]   count_q, idx_q;
  logic [2*W-1:0]  prod_q, sq_q;
  logic            neg_q, reb_q, esc_q;
  logic [12:0]     n_q;
  logic [63:0]     n2_q, kn_q, k2_q, m4_q;
  logic [63:0]     rem_r_q, rem_g_q, rem_b_q;
  logic [7:0]      qr_q, qg_q, qb_q;
  logic [2:0]      bit_q;
  logic            out_valid_q;
  logic            job_is_build_q;
  mbp_pkg::out_item_t out_q;

  mbp_pkg::coord_t op_a, op_b, fx, zr_m, zi_m, sr, si;
  logic [2*W-1:0]  ram_rdata;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_addr;
  logic            load_out;
  logic [64:0]     norm;
  logic [31:0]     limit, eff;
  logic [12:0]     k;
  logic [71:0]     den_sh, denb_sh;

  assign fx    = mbp_pkg::fx_from_prod(prod_q, neg_q);
  assign zr_m  = ram_rdata[2*W-1:W];
  assign zi_m  = ram_rdata[W-1:0];
  assign sr    = mbp_pkg::sat_add(zr_m, dr_q);
  assign si    = mbp_pkg::sat_add(zi_m, di_q);
  assign norm  = {1'b0, sq_q} + {1'b0, prod_q};
  assign limit = (32'(cfg_i.max_iter) < 32'(ORBIT_DEPTH)) ? 32'(cfg_i.max_iter)
                                                         : 32'(ORBIT_DEPTH);
  assign eff   = (32'(cfg_i.max_iter) < 32'(count_q)) ? 32'(cfg_i.max_iter) : 32'(count_q);
  assign k     = cfg_i.max_iter - n_q;
  assign den_sh  = {8'b0, m4_q} << bit_q;
  assign denb_sh = {7'b0, m4_q, 1'b0} << bit_q;
  assign load_out = (st_q == mbp_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  mbp_ram #(
    .WIDTH (2 * W),
    .DEPTH (ORBIT_DEPTH)
  ) u_orbit (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i ({zr_q, zi_q}),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= mbp_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d      = st_q;
    job_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = count_q[AW-1:0];
    op_a      = '0;
    op_b      = '0;
    case (st_q)
      mbp_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          st_d = (job_i.command == mbp_pkg::CMD_BUILD) ? mbp_pkg::ST_B_CHECK
                                                       : mbp_pkg::ST_P_CHECK;
        end
      end
      mbp_pkg::ST_B_CHECK: begin
        if (32'(count_q) >= limit) begin
          st_d = mbp_pkg::ST_DONE;
        end else begin
          mem_we = 1'b1;
          op_a = zr_q;
          op_b = zr_q;
          st_d = mbp_pkg::ST_B_1;
        end
      end
      mbp_pkg::ST_B_1: begin op_a = zi_q; op_b = zi_q; st_d = mbp_pkg::ST_B_2; end
      mbp_pkg::ST_B_2: begin op_a = zr_q; op_b = zi_q; st_d = mbp_pkg::ST_B_3; end
      mbp_pkg::ST_B_3: st_d = mbp_pkg::ST_B_4;
      mbp_pkg::ST_B_4: begin op_a = zr_q; op_b = zr_q; st_d = mbp_pkg::ST_B_5; end
      mbp_pkg::ST_B_5: begin op_a = zi_q; op_b = zi_q; st_d = mbp_pkg::ST_B_6; end
      mbp_pkg::ST_B_6: begin
        st_d = (norm > mbp_pkg::NormOrbit) ? mbp_pkg::ST_DONE : mbp_pkg::ST_B_CHECK;
      end
      mbp_pkg::ST_P_CHECK: begin
        mem_addr = idx_q[AW-1:0];
        if (32'(idx_q) >= eff) begin
          st_d = mbp_pkg::ST_DONE;
        end else begin
          mem_re = 1'b1;
          st_d = mbp_pkg::ST_P_0;
        end
      end
      mbp_pkg::ST_P_0: begin op_a = zr_m; op_b = dr_q; st_d = mbp_pkg::ST_P_1; end
      mbp_pkg::ST_P_1: begin op_a = zi_m; op_b = di_q; st_d = mbp_pkg::ST_P_2; end
      mbp_pkg::ST_P_2: begin op_a = zr_m; op_b = di_q; st_d = mbp_pkg::ST_P_3; end
      mbp_pkg::ST_P_3: begin op_a = zi_m; op_b = dr_q; st_d = mbp_pkg::ST_P_4; end
      mbp_pkg::ST_P_4: begin op_a = dr_q; op_b = dr_q; st_d = mbp_pkg::ST_P_5; end
      mbp_pkg::ST_P_5: begin op_a = di_q; op_b = di_q; st_d = mbp_pkg::ST_P_6; end
      mbp_pkg::ST_P_6: begin op_a = dr_q; op_b = di_q; st_d = mbp_pkg::ST_P_7; end
      mbp_pkg::ST_P_7: st_d = mbp_pkg::ST_P_8;
      mbp_pkg::ST_P_8: st_d = mbp_pkg::ST_P_9;
      mbp_pkg::ST_P_9: begin op_a = dr_q; op_b = dr_q; st_d = mbp_pkg::ST_P_10; end
      mbp_pkg::ST_P_10: begin op_a = di_q; op_b = di_q; st_d = mbp_pkg::ST_P_11; end
      mbp_pkg::ST_P_11: begin op_a = sr; op_b = sr; st_d = mbp_pkg::ST_P_12; end
      mbp_pkg::ST_P_12: begin op_a = si; op_b = si; st_d = mbp_pkg::ST_P_13; end
      mbp_pkg::ST_P_13: begin
        st_d = (norm > mbp_pkg::NormEscape) ? mbp_pkg::ST_C_0 : mbp_pkg::ST_P_CHECK;
      end
      mbp_pkg::ST_C_0: begin op_a = 32'(n_q); op_b = 32'(n_q); st_d = mbp_pkg::ST_C_1; end
      mbp_pkg::ST_C_1: begin op_a = 32'(k); op_b = 32'(n_q); st_d = mbp_pkg::ST_C_2; end
      mbp_pkg::ST_C_2: begin op_a = 32'(k); op_b = 32'(k); st_d = mbp_pkg::ST_C_3; end
      mbp_pkg::ST_C_3: begin
        op_a = 32'(cfg_i.max_iter);
        op_b = 32'(cfg_i.max_iter);
        st_d = mbp_pkg::ST_C_4;
      end
      mbp_pkg::ST_C_4: begin
        op_a = prod_q[W-1:0];
        op_b = prod_q[W-1:0];
        st_d = mbp_pkg::ST_C_5;
      end
      mbp_pkg::ST_C_5: begin op_a = kn_q[W-1:0]; op_b = n2_q[W-1:0]; st_d = mbp_pkg::ST_C_6; end
      mbp_pkg::ST_C_6: begin op_a = kn_q[W-1:0]; op_b = kn_q[W-1:0]; st_d = mbp_pkg::ST_C_7; end
      mbp_pkg::ST_C_7: begin op_a = kn_q[W-1:0]; op_b = k2_q[W-1:0]; st_d = mbp_pkg::ST_C_8; end
      mbp_pkg::ST_C_8: st_d = mbp_pkg::ST_DIV;
      mbp_pkg::ST_DIV: begin
        if (bit_q == 3'd0) begin
          st_d = mbp_pkg::ST_DONE;
        end
      end
      mbp_pkg::ST_DONE: begin
        if (load_out) begin
          st_d = mbp_pkg::ST_IDLE;
        end
      end
      default: st_d = mbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= (2*W)'(mbp_pkg::mag(op_a)) * (2*W)'(mbp_pkg::mag(op_b));
    neg_q  <= op_a[W-1] ^ op_b[W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cre_q       <= '0;
      cim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == mbp_pkg::ST_IDLE && job_valid_i && job_i.command == mbp_pkg::CMD_BUILD) begin
        count_q <= '0;
        cre_q   <= cfg_i.center_re;
        cim_q   <= cfg_i.center_im;
      end else if (mem_we) begin
        count_q <= count_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      mbp_pkg::ST_IDLE: begin
        zr_q  <= '0;
        zi_q  <= '0;
        dr_q  <= '0;
        di_q  <= '0;
        idx_q <= '0;
        reb_q <= 1'b0;
        esc_q <= 1'b0;
        dcr_q <= mbp_pkg::sat_sub(job_i.cx, cre_q);
        dci_q <= mbp_pkg::sat_sub(job_i.cy, cim_q);
      end
      mbp_pkg::ST_B_1: t1_q <= fx;
      mbp_pkg::ST_B_2: a_q <= mbp_pkg::sat_add(mbp_pkg::sat_sub(t1_q, fx), cre_q);
      mbp_pkg::ST_B_3: begin
        zr_q <= a_q;
        zi_q <= mbp_pkg::sat_add(mbp_pkg::sat_add(fx, fx), cim_q);
      end
      mbp_pkg::ST_B_5: sq_q <= prod_q;
      mbp_pkg::ST_P_1: t1_q <= fx;
      mbp_pkg::ST_P_2: begin
        a_q <= mbp_pkg::sat_add(mbp_pkg::sat_sub(t1_q, fx), mbp_pkg::sat_sub(t1_q, fx));
      end
      mbp_pkg::ST_P_3: t1_q <= fx;
      mbp_pkg::ST_P_4: begin
        b_q <= mbp_pkg::sat_add(mbp_pkg::sat_add(t1_q, fx), mbp_pkg::sat_add(t1_q, fx));
      end
      mbp_pkg::ST_P_5: t1_q <= fx;
      mbp_pkg::ST_P_6: a_q <= mbp_pkg::sat_add(a_q, mbp_pkg::sat_sub(t1_q, fx));
      mbp_pkg::ST_P_7: begin
        b_q <= mbp_pkg::sat_add(b_q, mbp_pkg::sat_add(fx, fx));
        a_q <= mbp_pkg::sat_add(a_q, dcr_q);
      end
      mbp_pkg::ST_P_8: begin
        dr_q <= a_q;
        di_q <= mbp_pkg::sat_add(b_q, dci_q);
      end
      mbp_pkg::ST_P_10: sq_q <= prod_q;
      mbp_pkg::ST_P_11: begin
        if (norm > mbp_pkg::NormRebase) begin
          reb_q <= 1'b1;
        end
      end
      mbp_pkg::ST_P_12: sq_q <= prod_q;
      mbp_pkg::ST_P_13: begin
        if (norm > mbp_pkg::NormEscape) begin
          esc_q <= 1'b1;
          n_q   <= 13'(idx_q);
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      mbp_pkg::ST_C_1: n2_q <= prod_q;
      mbp_pkg::ST_C_2: kn_q <= prod_q;
      mbp_pkg::ST_C_3: k2_q <= prod_q;
      mbp_pkg::ST_C_5: m4_q <= prod_q;
      mbp_pkg::ST_C_6: rem_r_q <= prod_q * mbp_pkg::PalR;
      mbp_pkg::ST_C_7: rem_g_q <= prod_q * mbp_pkg::PalG;
      mbp_pkg::ST_C_8: begin
        rem_b_q <= prod_q * mbp_pkg::PalB;
        bit_q   <= 3'd7;
      end
      mbp_pkg::ST_DIV: begin
        qr_q[bit_q] <= {8'b0, rem_r_q} >= den_sh;
        qg_q[bit_q] <= {8'b0, rem_g_q} >= den_sh;
        qb_q[bit_q] <= {8'b0, rem_b_q} >= denb_sh;
        if ({8'b0, rem_r_q} >= den_sh) begin
          rem_r_q <= rem_r_q - den_sh[63:0];
        end
        if ({8'b0, rem_g_q} >= den_sh) begin
          rem_g_q <= rem_g_q - den_sh[63:0];
        end
        if ({8'b0, rem_b_q} >= denb_sh) begin
          rem_b_q <= rem_b_q - denb_sh[63:0];
        end
        bit_q <= bit_q - 1'b1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_q.orbit_length <= 11'(count_q);
      out_q.needs_rebase <= reb_q;
      out_q.escaped      <= esc_q;
      if (esc_q) begin
        out_q.iterations <= n_q;
        out_q.color      <= {qr_q[7:3], qg_q[7:2], qb_q[7:3]};
      end else begin
        out_q.iterations <= job_is_build_q ? 13'd0 : cfg_i.max_iter;
        out_q.color      <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_is_build_q <= job_i.command == mbp_pkg::CMD_BUILD;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/mandelbrot_perturbation_pixel_core.sv
// Top level of the perturbation Mandelbrot pixel core: configuration registers,
// front end, job queue and iteration engine. Depends on mbp_pkg and all submodules.
//
// Usage: write the seven registers through cfg_we_i/cfg_index_i/cfg_wdata_i while idle.
// A command with command=0 builds the reference orbit from the centre; a command with
// command=1 renders the pixel at (column, row) against the last built orbit.
// Every command yields exactly one result transfer on the output channel.
// Input transfers complete when in_valid_i is high and in_stall_o is low; output
// transfers when out_valid_o is high and out_stall_i is low.
// A build stores the orbit one point at a time. A render runs each iteration
// through the one shared multiplier and adds the color gradient when the pixel
// escapes.
// One command is worked at a time by the engine; a two-entry queue and the front
// register keep taking commands while it works.
// Reset clears the queue, the orbit length, the latched reference point and the
// output valid, and loads the registers with their defaults. The orbit memory
// is not cleared. While the receiver stalls, the result holds and the engine
// waits with the next finished result.
module mandelbrot_perturbation_pixel_core #(
  parameter int unsigned ORBIT_DEPTH = mbp_pkg::OrbitDepthDef,
  parameter int unsigned MAX_COLUMNS = mbp_pkg::MaxColumnsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mbp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mbp_pkg::out_item_t out_data_o
);

  mbp_pkg::cfg_t cfg_q;
  logic          push_valid, push_ready, pop_valid, pop;
  mbp_pkg::job_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_re <= '0;
      cfg_q.center_im <= '0;
      cfg_q.left_edge <= 32'hF4000000;
      cfg_q.top_edge  <= 32'hF4000000;
      cfg_q.pitch_x   <= 31'd1258291;
      cfg_q.pitch_y   <= 31'd1258291;
      cfg_q.max_iter  <= 13'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mbp_pkg::CFG_CENTER_RE: cfg_q.center_re <= cfg_wdata_i;
        mbp_pkg::CFG_CENTER_IM: cfg_q.center_im <= cfg_wdata_i;
        mbp_pkg::CFG_LEFT_EDGE: cfg_q.left_edge <= cfg_wdata_i;
        mbp_pkg::CFG_TOP_EDGE:  cfg_q.top_edge  <= cfg_wdata_i;
        mbp_pkg::CFG_PITCH_X:   cfg_q.pitch_x   <= cfg_wdata_i[30:0];
        mbp_pkg::CFG_PITCH_Y:   cfg_q.pitch_y   <= cfg_wdata_i[30:0];
        mbp_pkg::CFG_MAX_ITER:  cfg_q.max_iter  <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  mbp_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  mbp_back #(
    .ORBIT_DEPTH (ORBIT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (pop_valid),
    .job_i       (pop_data),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/mbp_checker.sv
// Port-level checks of the pixel core and the bind that attaches them.
// Depends on mbp_pkg and mandelbrot_perturbation_pixel_core.
module mbp_checker #(
  parameter int unsigned ORBIT_DEPTH = mbp_pkg::OrbitDepthDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mbp_pkg::out_item_t out_data_o
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_interior_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.escaped |-> out_data_o.color == 16'd0)
    else $error("non-escaping result has a color");

  a_orbit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.orbit_length) <= ORBIT_DEPTH)
    else $error("orbit length beyond memory depth");

  a_escape_needs_orbit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.escaped |-> out_data_o.orbit_length != 11'd0)
    else $error("escape without a reference orbit");

endmodule

bind mandelbrot_perturbation_pixel_core mbp_checker #(
  .ORBIT_DEPTH (ORBIT_DEPTH)
) u_mbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### sim/tb_mandelbrot_perturbation_pixel_core.sv
// Self-checking testbench for the perturbation Mandelbrot pixel core.
// Build and render commands run against a fixed-point predictor in a scoreboard
// class, under random idling and stalls. Depends on mbp_pkg and the core.
`timescale 1ns / 100ps

module tb_mandelbrot_perturbation_pixel_core;
  import mbp_pkg::*;

  localparam int WatchdogLimit = 150000;

  class pixel_scoreboard;
    longint          c_re, c_im, left_x, top_y, ref_re, ref_im;
    longint unsigned step_x, step_y;
    int              iter_limit, orbit_len;
    longint          orb_re[1024];
    longint          orb_im[1024];
    out_item_t       pending_q[$];
    int              errors, builds, renders, escapes, rebases;

    function new();
      c_re = 0; c_im = 0; left_x = -201326592; top_y = -201326592;
      step_x = 1258291; step_y = 1258291; iter_limit = 64;
      orbit_len = 0; ref_re = 0; ref_im = 0;
    endfunction

    function longint clampc(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned absval(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    function longint fmul(longint a, longint b);
      longint unsigned p, lim;
      logic neg;
      neg = (a < 0) != (b < 0);
      p   = (absval(a) * absval(b)) >> FracBits;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (p > lim) p = lim;
      return neg ? -longint'(p) : longint'(p);
    endfunction

    function longint sadd(longint a, longint b);
      return clampc(a + b);
    endfunction

    function longint ssub(longint a, longint b);
      return clampc(a - b);
    endfunction

    function bit norm_above(longint a, longint b, int t);
      logic [64:0] s;
      s = {1'b0, absval(a) * absval(a)} + {1'b0, absval(b) * absval(b)};
      return s > (65'(t) << (2 * FracBits));
    endfunction

    function logic [15:0] gradient(longint unsigned n, longint unsigned m);
      longint unsigned k, m4, r, g, b;
      k  = m - n;
      m4 = m * m * m * m;
      r  = 2295 * k * n * n * n / m4;
      g  = 3825 * k * k * n * n / m4;
      b  = 4335 * k * k * k * n / (2 * m4);
      return 16'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hFF) >> 3));
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        CFG_CENTER_RE: c_re = longint'(signed'(v));
        CFG_CENTER_IM: c_im = longint'(signed'(v));
        CFG_LEFT_EDGE: left_x = longint'(signed'(v));
        CFG_TOP_EDGE:  top_y = longint'(signed'(v));
        CFG_PITCH_X:   step_x = v[30:0];
        CFG_PITCH_Y:   step_y = v[30:0];
        CFG_MAX_ITER:  iter_limit = v[12:0];
        default: ;
      endcase
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      longint zr, zi, nr, ni, dcr, dci, dr, di, a, b, qr, qi;
      int lim, eff, n;
      bit esc, reb;
      e = '0;
      zr = 0; zi = 0;
      if (it.command == CMD_BUILD) begin
        builds++;
        lim = (iter_limit < 1024) ? iter_limit : 1024;
        ref_re = c_re;
        ref_im = c_im;
        orbit_len = 0;
        for (int i = 0; i < lim; i++) begin
          orb_re[i] = zr;
          orb_im[i] = zi;
          orbit_len++;
          nr = sadd(ssub(fmul(zr, zr), fmul(zi, zi)), ref_re);
          ni = sadd(sadd(fmul(zr, zi), fmul(zr, zi)), ref_im);
          zr = nr;
          zi = ni;
          if (norm_above(zr, zi, 16)) break;
        end
      end else begin
        renders++;
        dcr = ssub(clampc(left_x + longint'(it.column) * longint'(step_x)), ref_re);
        dci = ssub(clampc(top_y + longint'(it.row) * longint'(step_y)), ref_im);
        eff = (iter_limit < orbit_len) ? iter_limit : orbit_len;
        dr = 0; di = 0; n = 0; esc = 0; reb = 0;
        while (n < eff) begin
          zr = orb_re[n];
          zi = orb_im[n];
          a  = ssub(fmul(zr, dr), fmul(zi, di));
          a  = sadd(a, a);
          b  = sadd(fmul(zr, di), fmul(zi, dr));
          b  = sadd(b, b);
          qr = ssub(fmul(dr, dr), fmul(di, di));
          qi = sadd(fmul(dr, di), fmul(dr, di));
          dr = sadd(sadd(a, qr), dcr);
          di = sadd(sadd(b, qi), dci);
          if (norm_above(dr, di, 64)) reb = 1;
          if (norm_above(sadd(zr, dr), sadd(zi, di), 4)) begin
            esc = 1;
            break;
          end
          n++;
        end
        if (!esc) n = iter_limit;
        escapes += esc;
        rebases += reb;
        e.iterations   = n[12:0];
        e.color        = esc ? gradient(n, iter_limit) : 16'd0;
        e.escaped      = esc;
        e.needs_rebase = reb;
      end
      e.orbit_length = orbit_len[10:0];
      pending_q.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(out_item_t r);
      out_item_t e;
      if (pending_q.size() == 0) begin
        report("result with none outstanding", r, 0);
        return;
      end
      e = pending_q.pop_front();
      if (r.iterations != e.iterations) report("iterations", r.iterations, e.iterations);
      if (r.color != e.color) report("color", r.color, e.color);
      if (r.escaped != e.escaped) report("escaped", r.escaped, e.escaped);
      if (r.needs_rebase != e.needs_rebase)
        report("needs_rebase", r.needs_rebase, e.needs_rebase);
      if (r.orbit_length != e.orbit_length)
        report("orbit_length", r.orbit_length, e.orbit_length);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  pixel_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  mandelbrot_perturbation_pixel_core uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_cycles <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog expired with %0d results outstanding", sb.pending_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(logic cmd, int col, int row);
    in_item_t it;
    it.command = cmd;
    it.column  = col[9:0];
    it.row     = row[9:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic random_setup(int mi_lo, int mi_hi);
    int cre, cim, px, py;
    if ($urandom_range(5) == 0) begin
      cfg_write(CFG_CENTER_RE, $urandom);
      cfg_write(CFG_CENTER_IM, $urandom);
      cfg_write(CFG_LEFT_EDGE, $urandom);
      cfg_write(CFG_TOP_EDGE, $urandom);
      cfg_write(CFG_PITCH_X, $urandom);
      cfg_write(CFG_PITCH_Y, $urandom);
    end else begin
      cre = int'($urandom_range(0, 3 << 27)) - (2 << 27);
      cim = int'($urandom_range(0, 5 << 26)) - (5 << 25);
      px  = $urandom_range(1 << 12, 1 << 20);
      py  = $urandom_range(1 << 12, 1 << 20);
      cfg_write(CFG_CENTER_RE, cre);
      cfg_write(CFG_CENTER_IM, cim);
      cfg_write(CFG_LEFT_EDGE, cre - px * 512);
      cfg_write(CFG_TOP_EDGE, cim - py * 512);
      cfg_write(CFG_PITCH_X, px);
      cfg_write(CFG_PITCH_Y, py);
    end
    cfg_write(CFG_MAX_ITER, $urandom_range(mi_lo, mi_hi));
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Render with no orbit yet, then the default view and its corners.
    send(CMD_RENDER, 5, 7);
    send(CMD_BUILD, 0, 0);
    send(CMD_RENDER, 0, 0);
    send(CMD_RENDER, 1023, 1023);
    send(CMD_RENDER, 1023, 0);
    send(CMD_RENDER, 0, 1023);
    send(CMD_RENDER, 400, 512);
    send(CMD_RENDER, 682, 341);
    drain();
    // Stale reference: new centre without a rebuild, then with one.
    cfg_write(CFG_CENTER_RE, 32'hF000_0000);
    send(CMD_RENDER, 300, 600);
    send(CMD_BUILD, 0, 0);
    send(CMD_RENDER, 300, 600);
    drain();
    cfg_write(CFG_MAX_ITER, 0);
    send(CMD_BUILD, 0, 0);
    send(CMD_RENDER, 512, 512);
    drain();
    cfg_write(CFG_MAX_ITER, 1);
    send(CMD_BUILD, 0, 0);
    send(CMD_RENDER, 1023, 1023);
    drain();
    // Saturating extremes of every register but the iteration limit.
    cfg_write(CFG_CENTER_RE, 32'h8000_0000);
    cfg_write(CFG_CENTER_IM, 32'h7FFF_FFFF);
    cfg_write(CFG_LEFT_EDGE, 32'h7FFF_FFFF);
    cfg_write(CFG_TOP_EDGE, 32'h8000_0000);
    cfg_write(CFG_PITCH_X, 32'h7FFF_FFFF);
    cfg_write(CFG_PITCH_Y, 32'h0);
    cfg_write(CFG_MAX_ITER, 8);
    send(CMD_BUILD, 0, 0);
    send(CMD_RENDER, 1023, 1023);
    send(CMD_RENDER, 0, 0);
    drain();
    cfg_write(CFG_CENTER_RE, 0);
    cfg_write(CFG_CENTER_IM, 0);
    cfg_write(CFG_LEFT_EDGE, 32'hFFFF_F000);
    cfg_write(CFG_TOP_EDGE, 32'hFFFF_F000);
    cfg_write(CFG_PITCH_X, 8);
    cfg_write(CFG_PITCH_Y, 8);
    cfg_write(CFG_MAX_ITER, 4096);
    send(CMD_BUILD, 0, 0);
    send(CMD_RENDER, 512, 512);
    send(CMD_RENDER, 1023, 0);
    drain();

    for (int blk = 0; blk < 8; blk++) begin
      case (blk % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      random_setup(1, (blk == 4) ? 4 : 40);
      if (blk == 4) hold_req++;
      send(CMD_BUILD, 0, 0);
      for (int k = 0; k < 115; k++) begin
        send(($urandom_range(99) < 6) ? CMD_BUILD : CMD_RENDER,
             $urandom_range(1023), $urandom_range(1023));
      end
      drain();
    end

    $display("Covered %0d builds and %0d renders, %0d escaping and %0d needing rebase.",
             sb.builds, sb.renders, sb.escapes, sb.rebases);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
